[rtl/core/modular_field_group_alu_macros.svh]
// Assertion macros shared by the modular arithmetic unit.
// Included by the modules that carry concurrent assertions.
`ifndef MODULAR_FIELD_GROUP_ALU_MACROS_SVH
`define MODULAR_FIELD_GROUP_ALU_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MFG_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MFG_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/mfg_pkg.sv]
// Shared types and constants of the modular arithmetic unit.
// No dependencies.
package mfg_pkg;

  localparam int DEF_OPERAND_WIDTH = 64;
  localparam int FUNC_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_FADD = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_FMUL = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_FNEG = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_GMUL = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_GEXP = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_PRESENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FMOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GMOD = 2'd2;

  typedef enum logic [2:0] {
    OP_FADD,
    OP_FMUL,
    OP_FNEG,
    OP_GMUL,
    OP_GEXP,
    OP_NONE,
    OP_ERR
  } op_t;

  localparam int OP_W = $bits(op_t);

endpackage

[rtl/core/mfg_if.sv]
// Valid/ready channel interfaces for operation requests and results.
// Depends on mfg_pkg.
interface mfg_in_if import mfg_pkg::*; #(parameter int W = DEF_OPERAND_WIDTH);
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [W-1:0]      lhs;
  logic [W-1:0]      rhs;
  modport source (output valid, func, lhs, rhs, input ready);
  modport sink (input valid, func, lhs, rhs, output ready);
endinterface

interface mfg_out_if import mfg_pkg::*; #(parameter int W = DEF_OPERAND_WIDTH);
  logic         valid;
  logic         ready;
  logic [W-1:0] result;
  logic         status;
  modport source (output valid, result, status, input ready);
  modport sink (input valid, result, status, output ready);
endinterface

[rtl/core/mfg_front.sv]
// Front end: accepts request beats and classifies the opcode.
// Depends on mfg_pkg and mfg_in_if.
module mfg_front import mfg_pkg::*; #(
  parameter int W = DEF_OPERAND_WIDTH
) (
  mfg_in_if.sink           in,
  input  logic             present,
  input  logic             q_full,
  output logic             q_push,
  output logic [OP_W+2*W-1:0] q_data
);

  op_t op;

  always_comb begin
    case (in.func)
      FUNC_FADD: op = OP_FADD;
      FUNC_FMUL: op = OP_FMUL;
      FUNC_FNEG: op = OP_FNEG;
      FUNC_GMUL: op = OP_GMUL;
      FUNC_GEXP: op = OP_GEXP;
      default:   op = OP_NONE;
    endcase
    if (!present) begin
      op = OP_ERR;
    end
  end

  assign in.ready = !q_full;
  assign q_push = in.valid && !q_full;
  assign q_data = {op, in.lhs, in.rhs};

endmodule

[rtl/core/mfg_queue.sv]
// Two-entry queue between the front end and the arithmetic back end.
// Depends on mfg_pkg for nothing but the shared style; stands alone.
module mfg_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        mem[wptr] <= wdata;
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign full = count[1];
  assign valid = count != 2'd0;
  assign rdata = mem[rptr];

endmodule

[rtl/core/mfg_back.sv]
// Back end: sequencer around a double-and-add modular multiplier.
// Depends on mfg_pkg, mfg_out_if and the assertion macros.
`include "modular_field_group_alu_macros.svh"
module mfg_back import mfg_pkg::*; #(
  parameter int W = DEF_OPERAND_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [W-1:0]        fmod,
  input  logic [W-1:0]        gmod,
  input  logic                q_valid,
  input  logic [OP_W+2*W-1:0] q_data,
  output logic                q_pop,
  mfg_out_if.source           out
);

  localparam int CW = (W > 1) ? $clog2(W) : 1;

  typedef enum logic [2:0] {IDLE, LOOP, NEXT, CHK, FIN} state_t;

  state_t       state;
  op_t          op;
  logic [1:0]   step;
  logic         ph;
  logic [CW-1:0] cnt;
  logic [W-1:0] a, b, r, x, y, e, m, rv, res;
  logic         st;
  logic         ovalid;
  logic         load_out;
  logic [W-1:0] result;
  logic         status;

  function automatic logic [W-1:0] addm(input logic [W-1:0] p, input logic [W-1:0] q,
                                        input logic [W-1:0] md);
    logic [W:0] s;
    logic [W:0] d;
    s = {1'b0, p} + {1'b0, q};
    d = s - {1'b0, md};
    if (md == '0) begin
      return s[W-1:0];
    end else if (s >= {1'b0, md}) begin
      return d[W-1:0];
    end
    return s[W-1:0];
  endfunction

  assign q_pop = (state == IDLE) && q_valid;
  assign load_out = (state == FIN) && (!ovalid || out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (load_out) begin
      ovalid <= 1'b1;
    end else if (out.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (q_valid) begin
            op <= op_t'(q_data[OP_W+2*W-1:2*W]);
            rv <= q_data[W-1:0];
            m <= (op_t'(q_data[OP_W+2*W-1:2*W]) == OP_GMUL ||
                  op_t'(q_data[OP_W+2*W-1:2*W]) == OP_GEXP) ? gmod : fmod;
            step <= 2'd0;
            if (op_t'(q_data[OP_W+2*W-1:2*W]) == OP_ERR ||
                op_t'(q_data[OP_W+2*W-1:2*W]) == OP_NONE) begin
              res <= '0;
              st <= op_t'(q_data[OP_W+2*W-1:2*W]) == OP_ERR;
              state <= FIN;
            end else begin
              a <= W'(1);
              b <= q_data[2*W-1:W];
              r <= '0;
              cnt <= CW'(W-1);
              ph <= 1'b0;
              st <= 1'b0;
              state <= LOOP;
            end
          end
        end
        LOOP: begin
          if (!ph) begin
            r <= addm(r, r, m);
            ph <= 1'b1;
          end else begin
            if (b[cnt]) begin
              r <= addm(r, a, m);
            end
            ph <= 1'b0;
            if (cnt == '0) begin
              state <= NEXT;
            end else begin
              cnt <= cnt - CW'(1);
            end
          end
        end
        NEXT: begin
          r <= '0;
          cnt <= CW'(W-1);
          ph <= 1'b0;
          step <= step + 2'd1;
          case (op)
            OP_FADD: begin
              if (step == 2'd0) begin
                x <= r;
                a <= W'(1);
                b <= rv;
                state <= LOOP;
              end else begin
                res <= addm(x, r, m);
                state <= FIN;
              end
            end
            OP_FMUL, OP_GMUL: begin
              if (step == 2'd0) begin
                a <= r;
                b <= rv;
                state <= LOOP;
              end else begin
                res <= r;
                state <= FIN;
              end
            end
            OP_FNEG: begin
              if (step == 2'd0) begin
                a <= W'(1);
                b <= m - r;
                state <= LOOP;
              end else begin
                res <= r;
                state <= FIN;
              end
            end
            OP_GEXP: begin
              case (step)
                2'd0: begin
                  x <= r;
                  a <= W'(1);
                  b <= W'(1);
                  state <= LOOP;
                end
                2'd1: begin
                  y <= r;
                  e <= rv;
                  state <= CHK;
                end
                2'd2: begin
                  y <= r;
                  a <= x;
                  b <= x;
                  state <= LOOP;
                end
                default: begin
                  x <= r;
                  e <= e >> 1;
                  state <= CHK;
                end
              endcase
            end
            default: begin
              res <= '0;
              state <= FIN;
            end
          endcase
        end
        CHK: begin
          r <= '0;
          cnt <= CW'(W-1);
          ph <= 1'b0;
          a <= x;
          if (e == '0) begin
            res <= y;
            state <= FIN;
          end else begin
            state <= LOOP;
            if (e[0]) begin
              b <= y;
              step <= 2'd2;
            end else begin
              b <= x;
              step <= 2'd3;
            end
          end
        end
        FIN: begin
          if (load_out) begin
            result <= res;
            status <= st;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign out.valid = ovalid;
  assign out.result = result;
  assign out.status = status;

  `MFG_ASSERT_IMP(a_pop_idle, clk, rst, q_pop, state == IDLE)
  `MFG_ASSERT_IMP(a_err_zero, clk, rst, ovalid && status, result == '0)
  `MFG_ASSERT_NXT(a_fin_idle, clk, rst, state == FIN && (!ovalid || out.ready),
                  state == IDLE && ovalid)

endmodule

[rtl/core/modular_field_group_alu.sv]
// Modular arithmetic unit: field add, multiply and negate under the field modulus, group
// multiply and exponentiation under the group modulus. One item is processed at a time by a
// double-and-add multiplier that doubles and then conditionally adds for each operand bit.
// Add reduces both operands before adding them; multiply and negate reduce the left operand
// and then multiply once; exponentiation squares for each exponent bit up to the highest set
// bit and multiplies once more for each set bit. A two-entry queue takes requests while the
// multiplier is busy; results wait in an output register until taken.
module modular_field_group_alu import mfg_pkg::*; #(
  parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  mfg_in_if.sink                   in,
  mfg_out_if.source                out,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [OPERAND_WIDTH-1:0] cfg_wdata
);

  localparam int W = OPERAND_WIDTH;
  localparam int DW = OP_W + 2 * W;

  logic          present;
  logic [W-1:0]  fmod;
  logic [W-1:0]  gmod;
  logic          q_push, q_full, q_pop, q_valid;
  logic [DW-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= 1'b0;
      fmod <= W'(1);
      gmod <= W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PRESENT: present <= cfg_wdata[0];
        REG_FMOD:    fmod <= cfg_wdata;
        REG_GMOD:    gmod <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  mfg_front #(.W(W)) u_front (
    .in(in), .present(present), .q_full(q_full), .q_push(q_push), .q_data(q_wdata)
  );

  mfg_queue #(.DW(DW)) u_queue (
    .clk(clk), .rst(rst), .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .valid(q_valid), .rdata(q_rdata)
  );

  mfg_back #(.W(W)) u_back (
    .clk(clk), .rst(rst), .fmod(fmod), .gmod(gmod), .q_valid(q_valid),
    .q_data(q_rdata), .q_pop(q_pop), .out(out)
  );

endmodule
